### rtl/core/abas_pkg.sv
// shared types and constants of the adc block average scaler
`default_nettype none

package abas_pkg;

    // raw converter word layout
    localparam int RAW_WORD_BITS = 16;
    localparam int RAW_BITS      = 14;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_LEN     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VREF_MV       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SCALE    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CUSTOM_FACTOR = 2'd3;

    // reset values of the configuration registers
    localparam logic [8:0]  BLOCK_LEN_RST     = 9'd16;
    localparam logic [15:0] VREF_MV_RST       = 16'd3300;
    localparam logic [15:0] FULL_SCALE_RST    = 16'd1023;
    localparam logic [15:0] CUSTOM_FACTOR_RST = 16'd256;

    // result field widths
    localparam int AVG_OUT_BITS = 10;
    localparam int MV_BITS      = 16;
    localparam int CV_OUT_BITS  = 32;
    localparam int SCALE_BITS   = 16;

    // depth of the block queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // back end sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_AVG   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } back_state_t;

    // queue status seen by front and back
    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // scaling registers used by the back end
    typedef struct packed {
        logic [SCALE_BITS-1:0] vref_mv;
        logic [SCALE_BITS-1:0] full_scale;
        logic [SCALE_BITS-1:0] factor;
    } scale_cfg_t;

endpackage

`default_nettype wire

### rtl/core/adc_block_average_scaler.sv
// top level of the adc block averager with millivolt and custom scaling
//
//  channel   direction  handshake            payload
//  in        request    in_valid / in_stall  raw_word
//  out       result     out_valid/out_stall  average_counts, millivolts, custom_value
//  cfg       write      cfg_write            cfg_index, cfg_data
//
// samples are taken one per cycle; in_stall rises only while the two-entry block queue is full
// a finished block passes through the back end as one step per quotient bit for the mean division,
// the ST_MUL and ST_SCALE multiplies, then one step per bit for the shared-loop millivolt and
// custom divisions
// rst_n clears the accumulator, count, queue and sequencer and loads the register defaults
// a waiting result does not block the front end; only a full queue holds off requests
`default_nettype none

module adc_block_average_scaler #(
    parameter int SAMPLE_BITS = 10,
    parameter int MAX_AVERAGE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  average_counts,
    output logic [15:0] millivolts,
    output logic [31:0] custom_value,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import abas_pkg::*;

    localparam int N_BITS   = $clog2(MAX_AVERAGE + 1);
    localparam int SUM_BITS = SAMPLE_BITS + N_BITS;
    localparam int JOB_BITS = SUM_BITS + N_BITS;

    logic [8:0]            block_len_reg;
    logic [SCALE_BITS-1:0] vref_mv_reg;
    logic [SCALE_BITS-1:0] full_scale_reg;
    logic [SCALE_BITS-1:0] factor_reg;
    scale_cfg_t            scale_cfg;
    queue_status_t         q_stat;
    logic                  push;
    logic [JOB_BITS-1:0]   push_data;
    logic                  pop;
    logic [JOB_BITS-1:0]   pop_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg  <= BLOCK_LEN_RST;
            vref_mv_reg    <= VREF_MV_RST;
            full_scale_reg <= FULL_SCALE_RST;
            factor_reg     <= CUSTOM_FACTOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLOCK_LEN:     block_len_reg  <= cfg_data[8:0];
                REG_VREF_MV:       vref_mv_reg    <= cfg_data;
                REG_FULL_SCALE:    full_scale_reg <= cfg_data;
                REG_CUSTOM_FACTOR: factor_reg     <= cfg_data;
                default:           block_len_reg  <= block_len_reg;
            endcase
        end
    end

    assign scale_cfg.vref_mv    = vref_mv_reg;
    assign scale_cfg.full_scale = full_scale_reg;
    assign scale_cfg.factor     = factor_reg;

    // accumulation front end
    abas_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_AVERAGE (MAX_AVERAGE),
        .N_BITS      (N_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_word    (raw_word),
        .block_len   (block_len_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    // finished block queue
    abas_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // division and scaling back end
    abas_back #(
        .N_BITS   (N_BITS),
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .pop_data       (pop_data),
        .pop            (pop),
        .cfg            (scale_cfg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .average_counts (average_counts),
        .millivolts     (millivolts),
        .custom_value   (custom_value)
    );

endmodule

`default_nettype wire

### rtl/core/abas_front.sv
// front end: sample extraction, block accumulation and block completion
`default_nettype none

module abas_front #(
    parameter int SAMPLE_BITS = 10,
    parameter int MAX_AVERAGE = 256,
    parameter int N_BITS      = 9,
    parameter int SUM_BITS    = 19
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     raw_word,
    input  logic [8:0]                      block_len,
    input  abas_pkg::queue_status_t         q_stat,
    output logic                            push,
    output logic [SUM_BITS+N_BITS-1:0]      push_data
);
    import abas_pkg::*;

    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [N_BITS-1:0]      count_reg;
    logic [N_BITS-1:0]      count_next;
    logic [N_BITS-1:0]      block_n;
    logic [RAW_BITS-1:0]    raw_low;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   accept;
    logic                   complete;

    // low 14 bits, top SAMPLE_BITS of them
    assign raw_low = raw_word[RAW_BITS-1:0];
    assign sample  = raw_low[RAW_BITS-1 -: SAMPLE_BITS];

    // block size clamped to 1..MAX_AVERAGE
    always_comb
    begin
        priority if (block_len == '0)
        begin
            block_n = N_BITS'(1);
        end
        else if (32'(block_len) > 32'(MAX_AVERAGE))
        begin
            block_n = N_BITS'(MAX_AVERAGE);
        end
        else
        begin
            block_n = N_BITS'(block_len);
        end
    end

    // request handshake, held off only by a full queue
    assign in_stall = q_stat.full;
    assign accept   = in_valid & ~in_stall;
    assign complete = (count_reg >= block_n);

    // finished block goes to the queue with its divisor
    assign push      = accept & complete;
    assign push_data = {sum_reg, block_n};

    // accumulate, or restart the block with this sample
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (complete)
            begin
                sum_next   = SUM_BITS'(sample);
                count_next = N_BITS'(1);
            end
            else
            begin
                sum_next   = sum_reg + SUM_BITS'(sample);
                count_next = count_reg + N_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/abas_queue.sv
// short queue of finished blocks between front and back
`default_nettype none

module abas_queue #(
    parameter int WIDTH = 28
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        pop_data,
    output abas_pkg::queue_status_t stat
);
    import abas_pkg::*;

    localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]     entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [FILL_BITS-1:0] fill_reg;
    logic [FILL_BITS-1:0] fill_next;

    assign stat.valid = (fill_reg != '0);
    assign stat.full  = (fill_reg == FILL_BITS'(QUEUE_DEPTH));
    assign pop_data   = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + FILL_BITS'(1);
            2'b01:   fill_next = fill_reg - FILL_BITS'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/abas_back.sv
// back end: block mean division, scaling multiplies and scaling division
`default_nettype none

module abas_back #(
    parameter int N_BITS   = 9,
    parameter int SUM_BITS = 19
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  abas_pkg::queue_status_t    q_stat,
    input  logic [SUM_BITS+N_BITS-1:0] pop_data,
    output logic                       pop,
    input  abas_pkg::scale_cfg_t       cfg,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [9:0]                 average_counts,
    output logic [15:0]                millivolts,
    output logic [31:0]                custom_value
);
    import abas_pkg::*;

    // mean keeps the sum width: a lowered block size can leave it above the sample range
    localparam int PROD_BITS = SCALE_BITS + SUM_BITS;
    localparam int CV_BITS   = PROD_BITS + SCALE_BITS;
    localparam int LOOP_MAX  = (CV_BITS > SUM_BITS) ? CV_BITS : SUM_BITS;
    localparam int STEP_BITS = $clog2(LOOP_MAX);

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [STEP_BITS-1:0]    step_reg;
    logic [STEP_BITS-1:0]    step_next;
    logic [N_BITS-1:0]       n_reg;
    logic [N_BITS-1:0]       n_next;
    logic [N_BITS-1:0]       rem_avg_reg;
    logic [N_BITS-1:0]       rem_avg_next;
    logic [SUM_BITS-1:0]     dvd_reg;
    logic [SUM_BITS-1:0]     dvd_next;
    logic [PROD_BITS-1:0]    prod_reg;
    logic [PROD_BITS-1:0]    prod_next;
    logic [CV_BITS-1:0]      mv_q_reg;
    logic [CV_BITS-1:0]      mv_q_next;
    logic [CV_BITS-1:0]      cv_q_reg;
    logic [CV_BITS-1:0]      cv_q_next;
    logic [SCALE_BITS-1:0]   mv_rem_reg;
    logic [SCALE_BITS-1:0]   mv_rem_next;
    logic [SCALE_BITS-1:0]   cv_rem_reg;
    logic [SCALE_BITS-1:0]   cv_rem_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [AVG_OUT_BITS-1:0] avg_out_reg;
    logic [MV_BITS-1:0]      mv_out_reg;
    logic [CV_OUT_BITS-1:0]  cv_out_reg;

    logic [N_BITS:0]         avg_trial;
    logic                    avg_ge;
    logic [SCALE_BITS-1:0]   fs_eff;
    logic [SCALE_BITS:0]     mv_trial;
    logic                    mv_ge;
    logic [SCALE_BITS:0]     cv_trial;
    logic                    cv_ge;
    logic                    load_out;
    logic [MV_BITS-1:0]      mv_sat;
    logic [CV_OUT_BITS-1:0]  cv_sat;

    // mean division step, remainder stays below the block size
    assign avg_trial = {rem_avg_reg, dvd_reg[SUM_BITS-1]};
    assign avg_ge    = (avg_trial >= {1'b0, n_reg});

    // scaling division steps, a zero full scale counts as one
    assign fs_eff   = (cfg.full_scale == '0) ? SCALE_BITS'(1) : cfg.full_scale;
    assign mv_trial = {mv_rem_reg, mv_q_reg[CV_BITS-1]};
    assign mv_ge    = (mv_trial >= {1'b0, fs_eff});
    assign cv_trial = {cv_rem_reg, cv_q_reg[CV_BITS-1]};
    assign cv_ge    = (cv_trial >= {1'b0, fs_eff});

    // saturation of the quotients
    assign mv_sat = (|mv_q_reg[CV_BITS-1:MV_BITS]) ? '1 : mv_q_reg[MV_BITS-1:0];
    assign cv_sat = (|cv_q_reg[CV_BITS-1:CV_OUT_BITS]) ? '1 : cv_q_reg[CV_OUT_BITS-1:0];

    // output register free or being emptied
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign pop      = (state_reg == ST_IDLE) && q_stat.valid;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        n_next       = n_reg;
        rem_avg_next = rem_avg_reg;
        dvd_next     = dvd_reg;
        prod_next    = prod_reg;
        mv_q_next    = mv_q_reg;
        cv_q_next    = cv_q_reg;
        mv_rem_next  = mv_rem_reg;
        cv_rem_next  = cv_rem_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    dvd_next     = pop_data[SUM_BITS+N_BITS-1:N_BITS];
                    n_next       = pop_data[N_BITS-1:0];
                    rem_avg_next = '0;
                    step_next    = STEP_BITS'(SUM_BITS - 1);
                    state_next   = ST_AVG;
                end
            end
            ST_AVG:
            begin
                rem_avg_next = avg_ge ? N_BITS'(avg_trial - {1'b0, n_reg})
                                      : N_BITS'(avg_trial);
                dvd_next     = {dvd_reg[SUM_BITS-2:0], avg_ge};
                step_next    = step_reg - STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_BITS'(cfg.vref_mv) * PROD_BITS'(dvd_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mv_q_next   = CV_BITS'(prod_reg);
                cv_q_next   = CV_BITS'(prod_reg) * CV_BITS'(cfg.factor);
                mv_rem_next = '0;
                cv_rem_next = '0;
                step_next   = STEP_BITS'(CV_BITS - 1);
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                mv_rem_next = mv_ge ? SCALE_BITS'(mv_trial - {1'b0, fs_eff})
                                    : SCALE_BITS'(mv_trial);
                cv_rem_next = cv_ge ? SCALE_BITS'(cv_trial - {1'b0, fs_eff})
                                    : SCALE_BITS'(cv_trial);
                mv_q_next   = {mv_q_reg[CV_BITS-2:0], mv_ge};
                cv_q_next   = {cv_q_reg[CV_BITS-2:0], cv_ge};
                step_next   = step_reg - STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    assign out_valid_next = load_out | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        n_reg       <= n_next;
        rem_avg_reg <= rem_avg_next;
        dvd_reg     <= dvd_next;
        prod_reg    <= prod_next;
        mv_q_reg    <= mv_q_next;
        cv_q_reg    <= cv_q_next;
        mv_rem_reg  <= mv_rem_next;
        cv_rem_reg  <= cv_rem_next;
        if (load_out)
        begin
            avg_out_reg <= AVG_OUT_BITS'(dvd_reg);
            mv_out_reg  <= mv_sat;
            cv_out_reg  <= cv_sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign average_counts = avg_out_reg;
    assign millivolts     = mv_out_reg;
    assign custom_value   = cv_out_reg;

endmodule

`default_nettype wire
